FILE: hdl/assert_macros.svh
// Assertion macros for the calendar conversion RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/e2c_pkg.sv
// Types and constants for the seconds-to-calendar converter.
// No dependencies; used by epoch_to_calendar.
`default_nettype none

package e2c_pkg;

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic        use_local;
	} e2c_in_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [7:0] years_since_1900;
		logic [8:0] day_of_year;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
	} e2c_out_t;

	localparam logic signed [17:0] ZONE_RESET   = -18'sd28800;
	// reciprocal of 60 and of 24 for 32-bit operands (shift 37 and 36)
	localparam logic [31:0]        RECIP_60     = 32'h8888_8889;
	localparam logic [31:0]        RECIP_24     = 32'hAAAA_AAAB;
	// reciprocal of 7 (shift 16) and of 1461 (shift 26), rounded down
	localparam logic [13:0]        RECIP_7      = 14'd9362;
	localparam logic [15:0]        RECIP_1461   = 16'd45933;
	// day count of 2100-03-01; from there a phantom 29 February is inserted
	localparam logic [15:0]        DAY_2100_MAR = 16'd47541;
	localparam logic [16:0]        DAYS_68_69   = 17'd731;
	localparam logic [11:0]        DAYS_CYCLE   = 12'd1461;
	localparam logic [7:0]         YEAR_BASE    = 8'd68;
	localparam logic [7:0]         YEAR_2100    = 8'd200;

	// First day of a month within the year
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
		logic [8:0] s;
		begin
			unique case (mon)
				4'd0:    s = 9'd0;
				4'd1:    s = 9'd31;
				4'd2:    s = 9'd59;
				4'd3:    s = 9'd90;
				4'd4:    s = 9'd120;
				4'd5:    s = 9'd151;
				4'd6:    s = 9'd181;
				4'd7:    s = 9'd212;
				4'd8:    s = 9'd243;
				4'd9:    s = 9'd273;
				4'd10:   s = 9'd304;
				default: s = 9'd334;
			endcase
			if (leap && mon >= 4'd2) begin
				s = s + 9'd1;
			end
			return s;
		end
	endfunction

endpackage

`default_nettype wire

FILE: hdl/epoch_to_calendar.sv
// Ten-stage pipeline from input acceptance to the result word,
// throughput one word per cycle; the whole pipe holds when the output is stalled.
// Years come from four-year cycles counted from 1968 with 2100 patched, months from
// a parallel compare against month starts. Reset clears all valid bits and loads
// the zone offset with -28800 seconds.
// Depends on e2c_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module epoch_to_calendar import e2c_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [17:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire e2c_in_t     in_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output e2c_out_t         out_word
);

	logic signed [17:0] zone_q;
	logic [9:0]         vld_q;
	logic               adv;

	// stage registers
	logic [31:0] t_s1, t_s2;
	logic [26:0] q1_s2, q1_s3;
	logic [20:0] q2_s3, q2_s4;
	logic [15:0] days_s4;
	logic [5:0]  sec_s3, sec_s4, sec_s5, sec_s6, sec_s7, sec_s8, sec_s9, sec_s10;
	logic [5:0]  min_s4, min_s5, min_s6, min_s7, min_s8, min_s9, min_s10;
	logic [4:0]  hr_s5, hr_s6, hr_s7, hr_s8, hr_s9, hr_s10;
	logic [16:0] e_s5, e_s6, wx_s5, wx_s6;
	logic        late_s5, late_s6, late_s7, late_s8;
	logic [14:0] qw_s6;
	logic [6:0]  qc_s6, qc_s7;
	logic [2:0]  wd_s7, wd_s8, wd_s9, wd_s10;
	logic [11:0] r_s7;
	logic [7:0]  yr_s8, yr_s9, yr_s10;
	logic [8:0]  yd_s8, yd_s9, doy_s9, doy_s10;
	logic        leap_s8, leap_s9;
	logic [3:0]  mon_s9, mon_s10;
	logic [4:0]  dom_s10;

	// combinational helpers
	logic [31:0] zone_ext, t_n;
	logic [63:0] p1, p2, p3;
	logic [31:0] q1x60, sec_d;
	logic [26:0] q2x60, min_d;
	logic [20:0] dx24, hr_d;
	logic        late_n;
	logic [16:0] e_n, wx_n;
	logic [30:0] p4;
	logic [32:0] p5;
	logic [16:0] w7, wr_d, cx, r0;
	logic [3:0]  wr4;
	logic [2:0]  wd_n;
	logic [11:0] r_n;
	logic [6:0]  qc_n;
	logic [1:0]  yi_n;
	logic [8:0]  yd_n;
	logic [7:0]  yr_n;
	logic [3:0]  mon_n;
	logic [8:0]  doy_n, dom_d;
	logic        time_ok, date_ok;

	// advance the whole pipe unless the output word is held
	assign adv      = !vld_q[9] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[9];

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[8:0], in_valid};
		end
	end

	// stage 1: apply the zone offset
	assign zone_ext = {{14{zone_q[17]}}, zone_q};
	assign t_n = in_word.use_local ? (in_word.epoch_seconds - zone_ext)
	                               : in_word.epoch_seconds;

	// stages 2 to 4: split off seconds, minutes and the day count by reciprocal products
	assign p1    = {32'd0, t_s1} * {32'd0, RECIP_60};
	assign q1x60 = ({5'd0, q1_s2} << 6) - ({5'd0, q1_s2} << 2);
	assign sec_d = t_s2 - q1x60;
	assign p2    = {37'd0, q1_s2} * {32'd0, RECIP_60};
	assign q2x60 = ({6'd0, q2_s3} << 6) - ({6'd0, q2_s3} << 2);
	assign min_d = q1_s3 - q2x60;
	assign p3    = {43'd0, q2_s3} * {32'd0, RECIP_24};

	// stage 5: hour, phantom leap day for 2100, cycle and weekday operands
	assign dx24   = ({5'd0, days_s4} << 4) + ({5'd0, days_s4} << 3);
	assign hr_d   = q2_s4 - dx24;
	assign late_n = days_s4 >= DAY_2100_MAR;
	assign e_n    = {1'b0, days_s4} + {16'd0, late_n} + DAYS_68_69;
	assign wx_n   = {1'b0, days_s4} + 17'd4;

	// stage 6: quotient estimates by 7 and by the four-year cycle
	assign p4 = {14'd0, wx_s5} * {17'd0, RECIP_7};
	assign p5 = {16'd0, e_s5} * {17'd0, RECIP_1461};

	// stage 7: remainders with one correction step
	assign w7   = ({2'd0, qw_s6} << 3) - {2'd0, qw_s6};
	assign wr_d = wx_s6 - w7;
	assign wr4  = wr_d[3:0];
	assign wd_n = (wr4 >= 4'd7) ? 3'(wr4 - 4'd7) : wr4[2:0];
	assign cx   = ({10'd0, qc_s6} << 10) + ({10'd0, qc_s6} << 8) + ({10'd0, qc_s6} << 7)
	            + ({10'd0, qc_s6} << 5) + ({10'd0, qc_s6} << 4) + ({10'd0, qc_s6} << 2)
	            + {10'd0, qc_s6};
	assign r0   = e_s6 - cx;
	always_comb begin
		if (r0[11:0] >= DAYS_CYCLE) begin
			r_n  = r0[11:0] - DAYS_CYCLE;
			qc_n = qc_s6 + 7'd1;
		end else begin
			r_n  = r0[11:0];
			qc_n = qc_s6;
		end
	end

	// stage 8: year within the cycle, first year of each cycle is leap
	always_comb begin
		priority if (r_s7 < 12'd366) begin
			yi_n = 2'd0;
			yd_n = r_s7[8:0];
		end else if (r_s7 < 12'd731) begin
			yi_n = 2'd1;
			yd_n = 9'(r_s7 - 12'd366);
		end else if (r_s7 < 12'd1096) begin
			yi_n = 2'd2;
			yd_n = 9'(r_s7 - 12'd731);
		end else begin
			yi_n = 2'd3;
			yd_n = 9'(r_s7 - 12'd1096);
		end
	end
	assign yr_n = YEAR_BASE + {qc_s7[5:0], 2'b00} + {6'd0, yi_n};

	// stage 9: month by parallel compare; drop the phantom day from day of year
	always_comb begin
		mon_n = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (yd_s8 >= month_start(leap_s8, 4'(m))) begin
				mon_n = 4'(m);
			end
		end
	end
	assign doy_n = yd_s8 - {8'd0, (late_s8 && yr_s8 == YEAR_2100)};

	// stage 10: day of month
	assign dom_d = yd_s9 - month_start(leap_s9, mon_s9) + 9'd1;

	// pipeline payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_n;
			t_s2    <= t_s1;
			q1_s2   <= p1[63:37];
			sec_s3  <= sec_d[5:0];
			q1_s3   <= q1_s2;
			q2_s3   <= p2[57:37];
			min_s4  <= min_d[5:0];
			q2_s4   <= q2_s3;
			days_s4 <= p3[51:36];
			sec_s4  <= sec_s3;
			hr_s5   <= hr_d[4:0];
			e_s5    <= e_n;
			wx_s5   <= wx_n;
			late_s5 <= late_n;
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			qw_s6   <= p4[30:16];
			qc_s6   <= p5[32:26];
			wx_s6   <= wx_s5;
			e_s6    <= e_s5;
			late_s6 <= late_s5;
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hr_s6   <= hr_s5;
			wd_s7   <= wd_n;
			r_s7    <= r_n;
			qc_s7   <= qc_n;
			late_s7 <= late_s6;
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hr_s7   <= hr_s6;
			yr_s8   <= yr_n;
			yd_s8   <= yd_n;
			leap_s8 <= (yi_n == 2'd0);
			late_s8 <= late_s7;
			wd_s8   <= wd_s7;
			sec_s8  <= sec_s7;
			min_s8  <= min_s7;
			hr_s8   <= hr_s7;
			mon_s9  <= mon_n;
			doy_s9  <= doy_n;
			yd_s9   <= yd_s8;
			leap_s9 <= leap_s8;
			yr_s9   <= yr_s8;
			wd_s9   <= wd_s8;
			sec_s9  <= sec_s8;
			min_s9  <= min_s8;
			hr_s9   <= hr_s8;
			dom_s10 <= dom_d[4:0];
			mon_s10 <= mon_s9;
			doy_s10 <= doy_s9;
			yr_s10  <= yr_s9;
			wd_s10  <= wd_s9;
			sec_s10 <= sec_s9;
			min_s10 <= min_s9;
			hr_s10  <= hr_s9;
		end
	end

	// result word
	always_comb begin
		out_word.second           = sec_s10;
		out_word.minute           = min_s10;
		out_word.hour             = hr_s10;
		out_word.weekday          = wd_s10;
		out_word.years_since_1900 = yr_s10;
		out_word.day_of_year      = doy_s10;
		out_word.month_index      = mon_s10;
		out_word.day_of_month     = dom_s10;
	end

	// range checks on the result word
	assign time_ok = out_word.second < 6'd60 && out_word.minute < 6'd60
	              && out_word.hour < 5'd24 && out_word.weekday < 3'd7;
	assign date_ok = out_word.month_index < 4'd12 && out_word.day_of_month != 5'd0
	              && out_word.day_of_year < 9'd366;

	`ASSERT_ALWAYS(a_time_range, !out_valid || time_ok, "time field out of range")
	`ASSERT_ALWAYS(a_date_range, !out_valid || date_ok, "date field out of range")
	`ASSERT_NEXT(a_enter, in_valid && in_ready, vld_q[0], "accepted word did not enter the pipe")

endmodule

`default_nettype wire

FILE: tb/sv/e2c_checker.sv
// Checker for the seconds-to-calendar converter: watches both channels,
// predicts each result word from the accepted input word and compares.
// Depends on e2c_pkg; the zone offset is mirrored from the config port.
module e2c_checker import e2c_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [17:0] cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire e2c_in_t     in_word,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire e2c_out_t    out_word,
	output int               fail_count,
	output int               pending_dates
);

	logic [17:0] zone_mirror;
	e2c_out_t    date_queue[$];

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// Walk years, then months, as the calendar defines them
	function automatic e2c_out_t calendar_of(input e2c_in_t w, input logic [17:0] zone);
		e2c_out_t r;
		logic [31:0] t;
		int unsigned days, yr, acc, ylen, rem, mon, mlen;
		int unsigned mlens[12] = '{31,28,31,30,31,30,31,31,30,31,30,31};
		t = w.epoch_seconds;
		if (w.use_local) t = t - {{14{zone[17]}}, zone};
		r.second = t % 60;
		t = t / 60;
		r.minute = t % 60;
		t = t / 60;
		r.hour = t % 24;
		days = t / 24;
		r.weekday = (days + 4) % 7;
		yr = 1970;
		acc = 0;
		forever begin
			ylen = leap_year(yr) ? 366 : 365;
			if (acc + ylen > days) break;
			acc += ylen;
			yr++;
		end
		r.years_since_1900 = yr - 1900;
		r.day_of_year = days - acc;
		rem = days - acc;
		for (mon = 0; mon < 12; mon++) begin
			mlen = (mon == 1) ? (leap_year(yr) ? 29 : 28) : mlens[mon];
			if (rem >= mlen) rem -= mlen;
			else break;
		end
		if (mon > 11) mon = 11;
		r.month_index = mon;
		r.day_of_month = rem + 1;
		return r;
	endfunction

	assign pending_dates = date_queue.size();

	// Mirror the offset, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		e2c_out_t exp_date;
		if (!arst_n) begin
			zone_mirror <= ZONE_RESET;
			fail_count  <= 0;
			date_queue.delete();
		end else begin
			if (cfg_wr_en) zone_mirror <= cfg_wr_data;
			if (in_valid && in_ready) date_queue.push_back(calendar_of(in_word, zone_mirror));
			if (out_valid && out_ready) begin
				if (date_queue.size() == 0) begin
					$error("result word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					exp_date = date_queue.pop_front();
					if (exp_date !== out_word) begin
						fail_count <= fail_count + 1;
						if (exp_date.second !== out_word.second)
							$error("second exp %0d got %0d", exp_date.second, out_word.second);
						if (exp_date.minute !== out_word.minute)
							$error("minute exp %0d got %0d", exp_date.minute, out_word.minute);
						if (exp_date.hour !== out_word.hour)
							$error("hour exp %0d got %0d", exp_date.hour, out_word.hour);
						if (exp_date.weekday !== out_word.weekday)
							$error("weekday exp %0d got %0d", exp_date.weekday,
								out_word.weekday);
						if (exp_date.years_since_1900 !== out_word.years_since_1900)
							$error("years_since_1900 exp %0d got %0d",
								exp_date.years_since_1900, out_word.years_since_1900);
						if (exp_date.day_of_year !== out_word.day_of_year)
							$error("day_of_year exp %0d got %0d", exp_date.day_of_year,
								out_word.day_of_year);
						if (exp_date.month_index !== out_word.month_index)
							$error("month_index exp %0d got %0d", exp_date.month_index,
								out_word.month_index);
						if (exp_date.day_of_month !== out_word.day_of_month)
							$error("day_of_month exp %0d got %0d", exp_date.day_of_month,
								out_word.day_of_month);
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb.sv
// Stimulus and verdict for the seconds-to-calendar converter.
// Depends on e2c_pkg, epoch_to_calendar and e2c_checker.
module tb;
	import e2c_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [17:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	e2c_in_t     in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	e2c_out_t    out_word;
	int          fail_count;
	int          pending_dates;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_cycles = 0;
	int          quiet_cycles = 0;
	logic        hold_tog = 1'b0;
	logic        hold_seen = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	epoch_to_calendar dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	e2c_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.fail_count(fail_count), .pending_dates(pending_dates)
	);

	// Receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen   <= hold_tog;
			hold_cycles <= 300;
			out_ready   <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || hold_cycles > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("epoch_to_calendar regression: fail");
			$finish;
		end
	end

	// Offer one word, hold it until accepted; drop valid only while idling
	task automatic send_word(input logic [31:0] secs, input logic local_sel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= '{epoch_seconds: secs, use_local: local_sel};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering, then wait until every word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drain, wait out the pipe, then write the offset
	task automatic set_zone(input logic [17:0] zone);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= zone;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] random_secs();
		case ($urandom_range(4))
			0: return $urandom_range(200000);
			1: return 32'hFFFF_FFFF - $urandom_range(200000);
			// near the month boundary at the end of February 2100
			2: return 32'd4107542400 + $urandom_range(172800) - 32'd86400;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [17:0] zones[6] = '{18'h20000, 18'h1FFFF, 18'sd86400, -18'sd86400, 18'd0,
			ZONE_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, wrap, leap days, 2100 non-leap
		send_word(32'd0, 1'b0);
		send_word(32'd0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'd951782400, 1'b0);
		send_word(32'd951868800, 1'b0);
		send_word(32'd68169600, 1'b0);
		send_word(32'd4107456000, 1'b0);
		send_word(32'd4107542400, 1'b0);
		send_word(32'd4133894399, 1'b0);
		send_word(32'd4133894400, 1'b0);
		send_word(32'd946684799, 1'b0);
		send_word(32'h5555_5555, 1'b1);
		send_word(32'hAAAA_AAAA, 1'b1);
		send_word(32'd28799, 1'b1);

		// Random phases across offsets and idling mixes
		for (int ph = 0; ph < 6; ph++) begin
			set_zone(zones[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			if (ph == 4) hold_tog <= ~hold_tog;
			for (int i = 0; i < 165; i++) send_word(random_secs(), $urandom_range(1));
		end

		drain();
		if (fail_count == 0)
			$display("epoch_to_calendar regression: pass");
		else
			$display("epoch_to_calendar regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/e2c_pkg.sv
hdl/epoch_to_calendar.sv
tb/sv/e2c_checker.sv
tb/sv/tb.sv
